// ===== rtl/ypcb_pkg.sv =====
// shared constants for the yaw pitch camera basis block
package ypcb_pkg;

    localparam int CUR_W  = 16;
    localparam int POS_W  = 32;
    localparam int BAS_W  = 16;
    localparam int SENS_W = 16;

    localparam logic [SENS_W-1:0] SENS_RESET = 16'd1049;

    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] TOL_Q60 = 64'h0028F5C28F5C28F6;

    localparam logic [31:0] ONE30     = 32'h4000_0000;
    localparam logic [31:0] PI30      = 32'((PI_Q60 + (64'd1 << 29)) >> 30);
    localparam logic [31:0] HALF_PI30 = 32'((PI_Q60 + (64'd1 << 30)) >> 31);

    // series terms, reciprocal of n(n-1) scaled by 2^41, rounded up
    localparam int TERMS = 8;
    localparam int REC_S = 41;
    localparam logic [63:0] REC_ONE = 64'd1 << REC_S;

    localparam logic [38:0] REC_SIN [TERMS] = '{
        39'((REC_ONE + 64'd271) / 64'd272),
        39'((REC_ONE + 64'd209) / 64'd210),
        39'((REC_ONE + 64'd155) / 64'd156),
        39'((REC_ONE + 64'd109) / 64'd110),
        39'((REC_ONE + 64'd71) / 64'd72),
        39'((REC_ONE + 64'd41) / 64'd42),
        39'((REC_ONE + 64'd19) / 64'd20),
        39'((REC_ONE + 64'd5) / 64'd6)
    };

    localparam logic [38:0] REC_COS [TERMS] = '{
        39'((REC_ONE + 64'd305) / 64'd306),
        39'((REC_ONE + 64'd239) / 64'd240),
        39'((REC_ONE + 64'd181) / 64'd182),
        39'((REC_ONE + 64'd131) / 64'd132),
        39'((REC_ONE + 64'd89) / 64'd90),
        39'((REC_ONE + 64'd55) / 64'd56),
        39'((REC_ONE + 64'd29) / 64'd30),
        39'((REC_ONE + 64'd11) / 64'd12)
    };

endpackage

// ===== rtl/ypcb_front.sv =====
// front end: sensitivity register, cursor deltas, scaled deltas, negated position
module ypcb_front #(
    parameter int ANGLE_FRAC_BITS = 20,
    parameter int DW = 34
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_sens_we,
    input  logic [ypcb_pkg::SENS_W-1:0]    i_sens_data,
    input  logic [ypcb_pkg::CUR_W-1:0]     i_cursor_x,
    input  logic [ypcb_pkg::CUR_W-1:0]     i_cursor_y,
    input  logic signed [ypcb_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [ypcb_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [ypcb_pkg::POS_W-1:0] i_pos_z,
    output logic signed [DW-1:0]           o_dyaw,
    output logic signed [DW-1:0]           o_dpitch,
    output logic signed [ypcb_pkg::POS_W-1:0] o_shift_x,
    output logic signed [ypcb_pkg::POS_W-1:0] o_shift_y,
    output logic signed [ypcb_pkg::POS_W-1:0] o_shift_z
);
    import ypcb_pkg::*;

    localparam int LSH = (ANGLE_FRAC_BITS >= 20) ? ANGLE_FRAC_BITS - 20 : 0;
    localparam int RSH = (ANGLE_FRAC_BITS < 20) ? 20 - ANGLE_FRAC_BITS : 1;
    localparam logic signed [63:0] RBIAS = 64'sd1 <<< (RSH - 1);

    logic [SENS_W-1:0] r_sens;
    logic [CUR_W-1:0]  r_prev_x;
    logic [CUR_W-1:0]  r_prev_y;

    function automatic logic signed [DW-1:0] scale(input logic [CUR_W-1:0] cur,
                                                   input logic [CUR_W-1:0] prev,
                                                   input logic [SENS_W-1:0] sens);
        logic signed [CUR_W:0]   d;
        logic signed [33:0]      v;
        logic signed [63:0]      w;
        d = $signed({1'b0, cur}) - $signed({1'b0, prev});
        v = 34'(d) * $signed(34'({1'b0, sens}));
        if (ANGLE_FRAC_BITS >= 20) begin
            w = 64'(v) <<< LSH;
        end else begin
            w = (64'(v) + RBIAS) >>> RSH;
        end
        return w[DW-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] neg_sat(input logic signed [POS_W-1:0] p);
        logic signed [POS_W-1:0] r;
        if (p == {1'b1, {(POS_W-1){1'b0}}}) begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            r = -p;
        end
        return r;
    endfunction

    assign o_dyaw    = scale(i_cursor_x, r_prev_x, r_sens);
    assign o_dpitch  = scale(i_cursor_y, r_prev_y, r_sens);
    assign o_shift_x = neg_sat(i_pos_x);
    assign o_shift_y = neg_sat(i_pos_y);
    assign o_shift_z = neg_sat(i_pos_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens   <= SENS_RESET;
            r_prev_x <= '0;
            r_prev_y <= '0;
        end else begin
            if (i_sens_we) begin
                r_sens <= i_sens_data;
            end
            if (i_accept) begin
                r_prev_x <= i_cursor_x;
                r_prev_y <= i_cursor_y;
            end
        end
    end

endmodule

// ===== rtl/ypcb_fifo.sv =====
// two-word queue between front and back end
module ypcb_fifo #(
    parameter int W = 164
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_data,
    input  logic         i_rd,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    import ypcb_pkg::*;

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_wr) - 2'(i_rd);
        end
    end

endmodule

// ===== rtl/ypcb_back.sv =====
// back end: angle update, wrap and clamp, shared-multiplier trig sequencer, result register
module ypcb_back #(
    parameter int ANGLE_FRAC_BITS = 20,
    parameter int BASIS_FRAC_BITS = 14,
    parameter int DW = 34
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [DW-1:0]              i_dyaw,
    input  logic signed [DW-1:0]              i_dpitch,
    input  logic signed [ypcb_pkg::POS_W-1:0] i_shift_x,
    input  logic signed [ypcb_pkg::POS_W-1:0] i_shift_y,
    input  logic signed [ypcb_pkg::POS_W-1:0] i_shift_z,
    output logic                              o_take,
    input  logic                              i_pop,
    output logic                              o_empty,
    output logic signed [ypcb_pkg::BAS_W-1:0] o_right_x,
    output logic signed [ypcb_pkg::BAS_W-1:0] o_right_y,
    output logic signed [ypcb_pkg::BAS_W-1:0] o_right_z,
    output logic signed [ypcb_pkg::BAS_W-1:0] o_up_x,
    output logic signed [ypcb_pkg::BAS_W-1:0] o_up_y,
    output logic signed [ypcb_pkg::BAS_W-1:0] o_up_z,
    output logic signed [ypcb_pkg::BAS_W-1:0] o_facing_x,
    output logic signed [ypcb_pkg::BAS_W-1:0] o_facing_y,
    output logic signed [ypcb_pkg::BAS_W-1:0] o_facing_z,
    output logic signed [ypcb_pkg::POS_W-1:0] o_shift_x,
    output logic signed [ypcb_pkg::POS_W-1:0] o_shift_y,
    output logic signed [ypcb_pkg::POS_W-1:0] o_shift_z
);
    import ypcb_pkg::*;

    localparam int F  = ANGLE_FRAC_BITS;
    localparam int AW = F + 4;
    localparam int SW = F + 15;
    localparam int VW = F + 16;
    localparam int QS = 30 - F;
    localparam int RCP_S = 16;
    localparam int BS = 30 - BASIS_FRAC_BITS;
    localparam logic [31:0] BRND = (BS > 0) ? (32'd1 << ((BS > 0) ? BS - 1 : 0)) : 32'd0;

    localparam logic [63:0] PI_A64   = (PI_Q60 + (64'd1 << (59 - F))) >> (60 - F);
    localparam logic [63:0] HPI_A64  = (PI_Q60 + (64'd1 << (60 - F))) >> (61 - F);
    localparam logic [63:0] TOL_A64  = (TOL_Q60 + (64'd1 << (59 - F))) >> (60 - F);
    localparam logic signed [SW-1:0] PI_S   = SW'(PI_A64);
    localparam logic signed [SW-1:0] LIM_S  = SW'(HPI_A64 - TOL_A64);
    localparam logic [VW-1:0]        TWO_PI = VW'(PI_A64 << 1);
    // reciprocal of two pi for the integer part of the offset yaw, rounded down
    localparam logic [15:0]          RCP    = 16'((64'd1 << (RCP_S + F)) / (PI_A64 << 1));

    typedef enum logic [14:0] {
        S_IDLE = 15'h0001,
        S_UPD  = 15'h0002,
        S_MOD  = 15'h0004,
        S_WRAP = 15'h0008,
        S_LD   = 15'h0010,
        S_SQ   = 15'h0020,
        S_X2   = 15'h0040,
        S_MA   = 15'h0080,
        S_MB   = 15'h0100,
        S_MC   = 15'h0200,
        S_FIN  = 15'h0400,
        S_END  = 15'h0800,
        S_PM   = 15'h1000,
        S_PR   = 15'h2000,
        S_OUT  = 15'h4000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic signed [AW-1:0]    r_yaw;
    logic signed [AW-1:0]    r_pitch;
    logic signed [DW-1:0]    r_dyaw;
    logic signed [DW-1:0]    r_dpitch;
    logic signed [POS_W-1:0] r_sh_x;
    logic signed [POS_W-1:0] r_sh_y;
    logic signed [POS_W-1:0] r_sh_z;
    logic [VW-1:0]           r_u;
    logic [15:0]             r_q;
    logic                    r_vneg;
    logic [3:0]              r_k;
    logic                    r_sel;
    logic                    r_cos;
    logic                    r_sneg;
    logic                    r_cneg;
    logic [30:0]             r_x;
    logic [31:0]             r_x2;
    logic [30:0]             r_t;
    logic [70:0]             r_prod;
    logic signed [31:0]      r_sn;
    logic signed [31:0]      r_sy;
    logic signed [31:0]      r_cy;
    logic signed [31:0]      r_sp;
    logic signed [31:0]      r_cp;
    logic signed [31:0]      r_m [4];
    logic                    r_full;

    logic [38:0]             mul_a;
    logic [31:0]             mul_b;
    logic [70:0]             prod_n;
    logic signed [SW-1:0]    yaw_sum;
    logic signed [SW-1:0]    pitch_sum;
    logic signed [VW-1:0]    v_off;
    logic [31:0]             q_prod;
    logic [VW-1:0]           rem_r;
    logic [VW-1:0]           wrap_r;
    logic signed [AW-1:0]    ang;
    logic signed [AW+QS-1:0] a30;
    logic [AW+QS-1:0]        amag;
    logic [31:0]             xc;
    logic [31:0]             sv;
    logic signed [32:0]      cvw;
    logic signed [31:0]      cs;
    logic [31:0]             mr;
    logic signed [31:0]      pa;
    logic signed [31:0]      pb;
    logic                    out_free;

    function automatic logic [30:0] mag(input logic signed [31:0] v);
        logic [31:0] m;
        m = v[31] ? 32'(-v) : 32'(v);
        return m[30:0];
    endfunction

    function automatic logic signed [BAS_W-1:0] to_basis(input logic signed [31:0] v);
        logic [31:0] u;
        logic [31:0] m;
        u = 32'(mag(v));
        if (BS > 0) begin
            u = (u + BRND) >> BS;
        end
        m = v[31] ? -u : u;
        return m[BAS_W-1:0];
    endfunction

    assign out_free = !r_full || i_pop;
    assign o_take   = (r_state == S_IDLE) && i_valid;
    assign o_empty  = !r_full;

    assign yaw_sum   = SW'(r_yaw) - SW'(r_dyaw);
    assign pitch_sum = SW'(r_pitch) + SW'(r_dpitch);
    assign v_off     = VW'(yaw_sum) + $signed(VW'(PI_S));
    // quotient estimate is exact or one low, one compare and subtract finishes
    assign q_prod    = 32'(r_u[VW-1:F]) * 32'(RCP);
    assign rem_r     = (r_u >= TWO_PI) ? r_u - TWO_PI : r_u;
    assign wrap_r    = r_vneg ? ((rem_r == '0) ? '0 : TWO_PI - rem_r) : rem_r;

    assign ang  = r_sel ? r_pitch : r_yaw;
    assign a30  = {ang, QS'(0)};
    assign amag = a30[AW+QS-1] ? (AW+QS)'(-a30) : (AW+QS)'(a30);
    assign xc   = (amag > (AW+QS)'(PI30)) ? PI30 : amag[31:0];

    assign sv  = (r_prod[61:30] > ONE30) ? ONE30 : r_prod[61:30];
    assign cvw = $signed({1'b0, ONE30}) - $signed({1'b0, r_prod[62:31]});
    assign cs  = cvw[32] ? 32'sd0 : (r_cneg ? -cvw[31:0] : cvw[31:0]);

    assign pa = r_k[1] ? r_cp : r_sp;
    assign pb = r_k[0] ? r_cy : r_sy;
    assign mr = r_prod[61:30] + 32'(r_prod[29]);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ: begin
                mul_a = 39'(r_x);
                mul_b = 32'(r_x);
            end
            S_MA: begin
                mul_a = 39'(r_t);
                mul_b = r_x2;
            end
            S_MB: begin
                mul_a = r_cos ? REC_COS[r_k[2:0]] : REC_SIN[r_k[2:0]];
                mul_b = r_prod[61:30];
            end
            S_FIN: begin
                mul_a = 39'(r_t);
                mul_b = r_cos ? r_x2 : 32'(r_x);
            end
            S_PM: begin
                mul_a = 39'(mag(pa));
                mul_b = 32'(mag(pb));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_n = 71'(mul_a) * 71'(mul_b);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_UPD;
            S_UPD: begin
                if (yaw_sum > PI_S || yaw_sum < -PI_S) begin
                    n_state = S_MOD;
                end else begin
                    n_state = S_LD;
                end
            end
            S_MOD:  if (r_k == 4'd1) n_state = S_WRAP;
            S_WRAP: n_state = S_LD;
            S_LD:   n_state = S_SQ;
            S_SQ:   n_state = S_X2;
            S_X2:   n_state = S_MA;
            S_MA:   n_state = S_MB;
            S_MB:   n_state = S_MC;
            S_MC:   n_state = (r_k == 4'(TERMS - 1)) ? S_FIN : S_MA;
            S_FIN:  n_state = S_END;
            S_END: begin
                if (!r_cos) begin
                    n_state = S_MA;
                end else if (!r_sel) begin
                    n_state = S_LD;
                end else begin
                    n_state = S_PM;
                end
            end
            S_PM:   n_state = S_PR;
            S_PR:   n_state = (r_k == 4'd3) ? S_OUT : S_PM;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_yaw   <= '0;
            r_pitch <= '0;
            r_full  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_UPD) begin
                if (!(yaw_sum > PI_S || yaw_sum < -PI_S)) begin
                    r_yaw <= yaw_sum[AW-1:0];
                end
                if (pitch_sum > LIM_S) begin
                    r_pitch <= LIM_S[AW-1:0];
                end else if (pitch_sum < -LIM_S) begin
                    r_pitch <= AW'(-LIM_S);
                end else begin
                    r_pitch <= pitch_sum[AW-1:0];
                end
            end
            if (r_state == S_WRAP) begin
                r_yaw <= AW'($signed(wrap_r) - $signed(VW'(PI_S)));
            end
            if (r_state == S_OUT && out_free) begin
                r_full <= 1'b1;
            end else if (i_pop) begin
                r_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod_n;
        case (r_state)
            S_IDLE: begin
                r_dyaw   <= i_dyaw;
                r_dpitch <= i_dpitch;
                r_sh_x   <= i_shift_x;
                r_sh_y   <= i_shift_y;
                r_sh_z   <= i_shift_z;
                r_sel    <= 1'b0;
            end
            S_UPD: begin
                r_vneg <= v_off[VW-1];
                r_u    <= v_off[VW-1] ? VW'(-v_off) : VW'(v_off);
                r_k    <= '0;
            end
            S_MOD: begin
                if (r_k == 4'd0) begin
                    r_q <= q_prod[31:RCP_S];
                end else begin
                    r_u <= r_u - VW'(r_q) * TWO_PI;
                end
                r_k <= r_k + 4'd1;
            end
            S_LD: begin
                r_sneg <= a30[AW+QS-1];
                if (xc > HALF_PI30) begin
                    r_x    <= 31'(PI30 - xc);
                    r_cneg <= 1'b1;
                end else begin
                    r_x    <= xc[30:0];
                    r_cneg <= 1'b0;
                end
            end
            S_X2: begin
                r_x2  <= 32'((64'(r_prod) + (64'd1 << 29)) >> 30);
                r_t   <= 31'(ONE30);
                r_k   <= '0;
                r_cos <= 1'b0;
            end
            S_MC: begin
                r_t <= 31'(ONE30) - 31'(r_prod[70:REC_S]);
                r_k <= r_k + 4'd1;
            end
            S_END: begin
                if (!r_cos) begin
                    r_sn  <= r_sneg ? -$signed(sv) : $signed(sv);
                    r_t   <= 31'(ONE30);
                    r_k   <= '0;
                    r_cos <= 1'b1;
                end else if (!r_sel) begin
                    r_sy  <= r_sn;
                    r_cy  <= cs;
                    r_sel <= 1'b1;
                end else begin
                    r_sp <= r_sn;
                    r_cp <= cs;
                    r_k  <= '0;
                end
            end
            S_PR: begin
                r_m[r_k[1:0]] <= (pa[31] != pb[31]) ? -$signed(mr) : $signed(mr);
                r_k <= r_k + 4'd1;
            end
            S_OUT: begin
                if (out_free) begin
                    o_right_x  <= to_basis(-r_cy);
                    o_right_y  <= '0;
                    o_right_z  <= to_basis(r_sy);
                    o_up_x     <= to_basis(r_m[0]);
                    o_up_y     <= to_basis(-r_cp);
                    o_up_z     <= to_basis(r_m[1]);
                    o_facing_x <= to_basis(r_m[2]);
                    o_facing_y <= to_basis(r_sp);
                    o_facing_z <= to_basis(r_m[3]);
                    o_shift_x  <= r_sh_x;
                    o_shift_y  <= r_sh_y;
                    o_shift_z  <= r_sh_z;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/yaw_pitch_camera_basis.sv =====
// top level of the yaw pitch camera basis block
// input channel: push/full queue; a word is taken when push is high and full is low
// each word carries an absolute cursor position and a Q16.16 camera position
// result channel: empty/pop queue; the oldest result sits on the o_ ports while
// empty is low and leaves when pop is high
// sensitivity is written through i_sens_we / i_sens_data; the user must write
// it only while idle, the block does not check it; the back end runs the sine
// and cosine series for yaw and pitch one term at a time on a single shared
// multiplier, and wraps the yaw through S_MOD and S_WRAP when it has to
// throughput is one word per back end pass, the two-word queue absorbs bursts
// a stalled receiver holds the result register; the back end then parks the
// next finished word and the input queue fills until full goes high
// reset clears yaw, pitch, the previous cursor, the queues and the result flag
// and restores the default sensitivity
module yaw_pitch_camera_basis #(
    parameter int ANGLE_FRAC_BITS = 20,
    parameter int BASIS_FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [ypcb_pkg::CUR_W-1:0]        i_cursor_x,
    input  logic [ypcb_pkg::CUR_W-1:0]        i_cursor_y,
    input  logic signed [ypcb_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [ypcb_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [ypcb_pkg::POS_W-1:0] i_pos_z,
    input  logic                              i_sens_we,
    input  logic [ypcb_pkg::SENS_W-1:0]       i_sens_data,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [ypcb_pkg::BAS_W-1:0] o_right_x,
    output logic signed [ypcb_pkg::BAS_W-1:0] o_right_y,
    output logic signed [ypcb_pkg::BAS_W-1:0] o_right_z,
    output logic signed [ypcb_pkg::BAS_W-1:0] o_up_x,
    output logic signed [ypcb_pkg::BAS_W-1:0] o_up_y,
    output logic signed [ypcb_pkg::BAS_W-1:0] o_up_z,
    output logic signed [ypcb_pkg::BAS_W-1:0] o_facing_x,
    output logic signed [ypcb_pkg::BAS_W-1:0] o_facing_y,
    output logic signed [ypcb_pkg::BAS_W-1:0] o_facing_z,
    output logic signed [ypcb_pkg::POS_W-1:0] o_shift_x,
    output logic signed [ypcb_pkg::POS_W-1:0] o_shift_y,
    output logic signed [ypcb_pkg::POS_W-1:0] o_shift_z
);
    import ypcb_pkg::*;

    localparam int DW = ANGLE_FRAC_BITS + 14;
    localparam int QW = 2 * DW + 3 * POS_W;

    logic                    accept;
    logic                    q_full;
    logic                    q_valid;
    logic                    q_take;
    logic [QW-1:0]           q_wdata;
    logic [QW-1:0]           q_rdata;
    logic signed [DW-1:0]    f_dyaw;
    logic signed [DW-1:0]    f_dpitch;
    logic signed [POS_W-1:0] f_sh_x;
    logic signed [POS_W-1:0] f_sh_y;
    logic signed [POS_W-1:0] f_sh_z;

    assign accept  = push && !q_full;
    assign full    = q_full;
    assign q_wdata = {f_dyaw, f_dpitch, f_sh_x, f_sh_y, f_sh_z};

    ypcb_front #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
        .DW(DW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_sens_we   (i_sens_we),
        .i_sens_data (i_sens_data),
        .i_cursor_x  (i_cursor_x),
        .i_cursor_y  (i_cursor_y),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .o_dyaw      (f_dyaw),
        .o_dpitch    (f_dpitch),
        .o_shift_x   (f_sh_x),
        .o_shift_y   (f_sh_y),
        .o_shift_z   (f_sh_z)
    );

    ypcb_fifo #(
        .W(QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_data  (q_wdata),
        .i_rd    (q_take),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    ypcb_back #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
        .BASIS_FRAC_BITS(BASIS_FRAC_BITS),
        .DW(DW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_dyaw     (q_rdata[QW-1 -: DW]),
        .i_dpitch   (q_rdata[QW-DW-1 -: DW]),
        .i_shift_x  (q_rdata[3*POS_W-1 -: POS_W]),
        .i_shift_y  (q_rdata[2*POS_W-1 -: POS_W]),
        .i_shift_z  (q_rdata[POS_W-1:0]),
        .o_take     (q_take),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_right_x  (o_right_x),
        .o_right_y  (o_right_y),
        .o_right_z  (o_right_z),
        .o_up_x     (o_up_x),
        .o_up_y     (o_up_y),
        .o_up_z     (o_up_z),
        .o_facing_x (o_facing_x),
        .o_facing_y (o_facing_y),
        .o_facing_z (o_facing_z),
        .o_shift_x  (o_shift_x),
        .o_shift_y  (o_shift_y),
        .o_shift_z  (o_shift_z)
    );

endmodule

// ===== tb/sv/yaw_pitch_camera_basis_tb.sv =====
// self-checking testbench for the yaw pitch camera basis block
`timescale 1ns / 100ps

module yaw_pitch_camera_basis_tb;
    import ypcb_pkg::*;

    localparam longint PI_ANG   = longint'((PI_Q60 + (64'd1 << 39)) >> 40);
    localparam longint HALF_ANG = longint'((PI_Q60 + (64'd1 << 40)) >> 41);
    localparam longint TOL_ANG  = longint'((TOL_Q60 + (64'd1 << 39)) >> 40);
    localparam longint PITCH_MAX = HALF_ANG - TOL_ANG;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        bit                hold;
        logic [CUR_W-1:0]  cx;
        logic [CUR_W-1:0]  cy;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic [POS_W-1:0]  pz;
    } pose_word_t;

    typedef struct {
        logic [BAS_W-1:0] basis [9];
        logic [POS_W-1:0] shift [3];
    } basis_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic [CUR_W-1:0] i_cursor_x = '0, i_cursor_y = '0;
    logic signed [POS_W-1:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic i_sens_we = 1'b0;
    logic [SENS_W-1:0] i_sens_data = '0;
    logic signed [BAS_W-1:0] o_right_x, o_right_y, o_right_z, o_up_x, o_up_y, o_up_z;
    logic signed [BAS_W-1:0] o_facing_x, o_facing_y, o_facing_z;
    logic signed [POS_W-1:0] o_shift_x, o_shift_y, o_shift_z;

    pose_word_t  pending_words [$];
    basis_word_t expected_basis [$];
    pose_word_t  cur_word;
    longint yaw, pitch, sens;
    logic [CUR_W-1:0] last_cx, last_cy, gen_cx, gen_cy;
    int errors = 0;
    int send_gap = 0, recv_gap = 0;
    bit send_burst = 0, recv_burst = 0;
    longint cycles = 0;

    yaw_pitch_camera_basis DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_cursor_x(i_cursor_x), .i_cursor_y(i_cursor_y),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_sens_we(i_sens_we), .i_sens_data(i_sens_data),
        .empty(empty), .pop(pop),
        .o_right_x(o_right_x), .o_right_y(o_right_y), .o_right_z(o_right_z),
        .o_up_x(o_up_x), .o_up_y(o_up_y), .o_up_z(o_up_z),
        .o_facing_x(o_facing_x), .o_facing_y(o_facing_y), .o_facing_z(o_facing_z),
        .o_shift_x(o_shift_x), .o_shift_y(o_shift_y), .o_shift_z(o_shift_z)
    );

    always #5 i_clk = ~i_clk;

    function automatic void sin_cos(input longint a, output longint sn, output longint cs);
        bit sneg, cneg;
        bit [63:0] x, x2, t, sv;
        longint cv;
        int n;
        sneg = a < 0;
        cneg = 0;
        x = sneg ? 64'(-a) : 64'(a);
        if (x > PI30) x = PI30;
        if (x > HALF_PI30) begin
            x = PI30 - x;
            cneg = 1;
        end
        x2 = (x * x + (64'd1 << 29)) >> 30;
        t = ONE30;
        for (n = 17; n >= 3; n -= 2)
            t = ONE30 - ((x2 * t) >> 30) / 64'(n * (n - 1));
        sv = (x * t) >> 30;
        if (sv > ONE30) sv = ONE30;
        t = ONE30;
        for (n = 18; n >= 4; n -= 2)
            t = ONE30 - ((x2 * t) >> 30) / 64'(n * (n - 1));
        cv = longint'(ONE30) - longint'(((x2 * t) >> 30) / 2);
        if (cv < 0) cv = 0;
        sn = sneg ? -longint'(sv) : longint'(sv);
        cs = cneg ? -cv : cv;
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        bit [63:0] ua, ub;
        longint m;
        ua = a < 0 ? 64'(-a) : 64'(a);
        ub = b < 0 ? 64'(-b) : 64'(b);
        m = longint'((ua * ub + (64'd1 << 29)) >> 30);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic logic [BAS_W-1:0] to_q14(longint v);
        bit [63:0] u;
        u = v < 0 ? 64'(-v) : 64'(v);
        u = (u + (64'd1 << 15)) >> 16;
        return v < 0 ? BAS_W'(-u) : BAS_W'(u);
    endfunction

    function automatic logic [POS_W-1:0] negate_sat(logic signed [POS_W-1:0] p);
        longint v;
        v = -longint'(p);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        return POS_W'(v);
    endfunction

    function automatic basis_word_t camera_basis(pose_word_t w);
        basis_word_t r;
        longint r2, sy, cy, sp, cp;
        yaw -= (longint'(w.cx) - longint'(last_cx)) * sens;
        pitch += (longint'(w.cy) - longint'(last_cy)) * sens;
        last_cx = w.cx;
        last_cy = w.cy;
        if (yaw > PI_ANG || yaw < -PI_ANG) begin
            r2 = (yaw + PI_ANG) % (2 * PI_ANG);
            if (r2 < 0) r2 += 2 * PI_ANG;
            yaw = r2 - PI_ANG;
        end
        if (pitch > PITCH_MAX) pitch = PITCH_MAX;
        else if (pitch < -PITCH_MAX) pitch = -PITCH_MAX;
        sin_cos(yaw * 1024, sy, cy);
        sin_cos(pitch * 1024, sp, cp);
        r.basis[0] = to_q14(-cy);
        r.basis[1] = '0;
        r.basis[2] = to_q14(sy);
        r.basis[3] = to_q14(mul_q30(sp, sy));
        r.basis[4] = to_q14(-cp);
        r.basis[5] = to_q14(mul_q30(sp, cy));
        r.basis[6] = to_q14(mul_q30(cp, sy));
        r.basis[7] = to_q14(sp);
        r.basis[8] = to_q14(mul_q30(cp, cy));
        r.shift[0] = negate_sat(w.px);
        r.shift[1] = negate_sat(w.py);
        r.shift[2] = negate_sat(w.pz);
        return r;
    endfunction

    // sender
    always @(posedge i_clk) begin
        bit take, nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            take = push && !full;
            nxt = push && !take;
            if (take) begin
                expected_basis.push_back(camera_basis(cur_word));
                if ($urandom_range(0, 40) == 0) send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 18);
            end
            if (!nxt) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_words.size() > 0) begin
                    if (pending_words[0].hold) begin
                        if (expected_basis.size() == 0) void'(pending_words.pop_front());
                    end else begin
                        cur_word = pending_words.pop_front();
                        i_cursor_x <= cur_word.cx;
                        i_cursor_y <= cur_word.cy;
                        i_pos_x <= cur_word.px;
                        i_pos_y <= cur_word.py;
                        i_pos_z <= cur_word.pz;
                        nxt = 1;
                    end
                end
            end
            push <= nxt;
        end
    end

    function automatic void check_field(string nm, longint e, longint a);
        if (e != a) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, nm, e, a);
        end
    endfunction

    // receiver
    always @(posedge i_clk) begin
        basis_word_t e;
        bit nxt;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            nxt = pop;
            if (pop && !empty) begin
                if (expected_basis.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none actual shift_x %0d",
                             $time, o_shift_x);
                end else begin
                    e = expected_basis.pop_front();
                    check_field("right_x", $signed(e.basis[0]), o_right_x);
                    check_field("right_y", $signed(e.basis[1]), o_right_y);
                    check_field("right_z", $signed(e.basis[2]), o_right_z);
                    check_field("up_x", $signed(e.basis[3]), o_up_x);
                    check_field("up_y", $signed(e.basis[4]), o_up_y);
                    check_field("up_z", $signed(e.basis[5]), o_up_z);
                    check_field("facing_x", $signed(e.basis[6]), o_facing_x);
                    check_field("facing_y", $signed(e.basis[7]), o_facing_y);
                    check_field("facing_z", $signed(e.basis[8]), o_facing_z);
                    check_field("shift_x", $signed(e.shift[0]), o_shift_x);
                    check_field("shift_y", $signed(e.shift[1]), o_shift_y);
                    check_field("shift_z", $signed(e.shift[2]), o_shift_z);
                end
                if ($urandom_range(0, 40) == 0) recv_burst = !recv_burst;
                recv_gap = recv_burst ? 0 : $urandom_range(0, 18);
                nxt = 0;
            end
            if (!nxt) begin
                if (recv_gap > 0) recv_gap--;
                else nxt = 1;
            end
            pop <= nxt;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("yaw_pitch_camera_basis verification failed");
            $finish;
        end
    end

    task automatic add_word(logic [15:0] cx, logic [15:0] cy,
                            logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        pose_word_t w;
        w.hold = 0;
        w.cx = cx;
        w.cy = cy;
        w.px = px;
        w.py = py;
        w.pz = pz;
        pending_words.push_back(w);
        gen_cx = cx;
        gen_cy = cy;
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_random(int count);
        int k;
        logic [15:0] cx, cy;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                cx = 16'($urandom);
                cy = 16'($urandom);
            end else begin
                cx = gen_cx + 16'(int'($urandom_range(0, 400)) - 200);
                cy = gen_cy + 16'(int'($urandom_range(0, 400)) - 200);
            end
            add_word(cx, cy, rand_pos(), rand_pos(), rand_pos());
        end
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || push || expected_basis.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_sens(logic [15:0] v);
        wait_idle();
        i_sens_we <= 1'b1;
        i_sens_data <= v;
        @(posedge i_clk);
        i_sens_we <= 1'b0;
        sens = v;
    endtask

    initial begin
        pose_word_t hold_w;
        sens = SENS_RESET;
        yaw = 0;
        pitch = 0;
        last_cx = '0;
        last_cy = '0;
        gen_cx = '0;
        gen_cy = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first word measured from cursor origin, position extremes
        add_word(16'd0, 16'd0, 32'h8000_0000, 32'h7fff_ffff, 32'd0);
        add_word(16'd1, 16'd1, 32'hffff_ffff, 32'd1, 32'h8000_0000);
        add_word(16'hffff, 16'hffff, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        add_word(16'd0, 16'd0, 32'h5555_5555, 32'haaaa_aaaa, 32'd0);
        add_word(16'hffff, 16'd0, 32'haaaa_aaaa, 32'h5555_5555, 32'h0001_0000);
        add_word(16'd0, 16'hffff, 32'd0, 32'd0, 32'd0);
        add_word(16'd3000, 16'd1500, 32'd0, 32'd0, 32'd0);
        add_word(16'd6000, 16'd0, 32'd0, 32'd0, 32'd0);
        add_word(16'd500, 16'd3000, 32'd0, 32'd0, 32'd0);
        add_word(16'd500, 16'd3000, 32'd0, 32'd0, 32'd0);
        hold_w.hold = 1;
        pending_words.push_back(hold_w);
        add_word(16'h8000, 16'h7fff, 32'h8000_0001, 32'h7fff_fffe, 32'd1);
        add_random(190);

        write_sens(16'd0);
        add_random(150);
        write_sens(16'hffff);
        add_random(150);
        write_sens(16'd1);
        add_random(150);
        write_sens(16'($urandom));
        add_random(150);
        write_sens(16'd300);
        add_random(200);
        write_sens(SENS_RESET);
        add_random(150);

        wait_idle();
        repeat (300) @(posedge i_clk);
        if (errors == 0 && expected_basis.size() == 0) begin
            $display("yaw_pitch_camera_basis verification clean");
        end else begin
            $display("yaw_pitch_camera_basis verification failed");
        end
        $finish;
    end

endmodule
